// ===== hw/rtl/pmftl_pkg.sv =====
package pmftl_pkg;

  localparam int BLOCK_COUNT    = 64;
  localparam int PAGES_IN_BLOCK = 64;
  localparam int LOGICAL_PAGES  = 2048;
  localparam int MAX_GC_ROUNDS  = 64;
  localparam int TOTAL_PAGES    = BLOCK_COUNT * PAGES_IN_BLOCK;

  localparam logic [5:0] FREE_THR_RESET = 6'd3;
  localparam logic [7:0] WEAR_GAP_RESET = 8'd5;

  // action codes; the spare code behaves as a read
  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_WEAR  = 2'd2;
  localparam logic [1:0] ACT_SPARE = 2'd3;

  // configuration register indexes
  localparam logic CFG_FREE_THR = 1'b0;
  localparam logic CFG_WEAR_GAP = 1'b1;

  typedef struct packed {
    logic [5:0] free_thr;
    logic [7:0] wear_gap;
  } cfg_t;

  // logical page map entry
  typedef struct packed {
    logic       vld;
    logic [5:0] blk;
    logic [5:0] pg;
  } map_ent_t;

  // physical page entry; only pages below the fill level are ever read
  typedef struct packed {
    logic        vld;
    logic [10:0] lpn;
  } page_ent_t;

  // per-block bookkeeping
  typedef struct packed {
    logic [6:0]  fill;
    logic [6:0]  vcnt;
    logic [6:0]  icnt;
    logic [31:0] ecnt;
  } blk_ent_t;

  typedef enum logic [15:0] {
    S_CLEAR   = 16'h0001,
    S_IDLE    = 16'h0002,
    S_MAP0    = 16'h0004,
    S_SCAN    = 16'h0008,
    S_DECIDE  = 16'h0010,
    S_MV_RD   = 16'h0020,
    S_MV_DAT  = 16'h0040,
    S_MV_WDST = 16'h0080,
    S_MV_WVIC = 16'h0100,
    S_FIN     = 16'h0200,
    S_INV_RD  = 16'h0400,
    S_INV_WR  = 16'h0800,
    S_PRG_RD  = 16'h1000,
    S_PRG_WR  = 16'h2000,
    S_OUT_RD  = 16'h4000,
    S_OUT     = 16'h8000
  } state_t;

  function automatic logic [31:0] sat_inc32(input logic [31:0] x);
    sat_inc32 = (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
  endfunction

endpackage

// ===== hw/rtl/page_mapped_ftl_greedy_gc_top.sv =====
// Page-mapped flash translation layer with greedy garbage collection.
// Command channel: an item (action, logical_page) transfers on a clock edge
// with start high and busy low. Action read reports the mapping, write
// collects garbage as needed then programs the page, wear level relocates
// the least-erased block when the erase gap is exceeded.
// Result: done is high for exactly one cycle with status, was_mapped,
// phys_block, phys_page and the two write counters; the receiver cannot
// stall it. One item is in flight at a time.
// Sequence: a read passes through S_MAP0 to S_OUT, and the next transfer
// is taken once the block is back in S_IDLE. A write scans the 64-entry
// block table, then invalidates any old copy and programs the page. A wear
// level scans the table as well and, when it relocates, reads every
// programmed page of the block. Each collection round rescans the table
// and reads every programmed page in the victim, copying the valid ones,
// the page memory read port setting the pace. Up to 64 rounds per write.
// Configuration: cfg_valid/cfg_ready write channel, always ready; index 0
// is the free block threshold, index 1 the wear gap threshold.
// Reset: rst clears the counters and then a clearing pass runs over the
// 2048-entry map memory with busy high; configuration is taken meanwhile.
module page_mapped_ftl_greedy_gc_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [1:0]  action,
  input  logic [10:0] logical_page,
  output logic        busy,
  output logic        done,
  output logic        status,
  output logic        was_mapped,
  output logic [5:0]  phys_block,
  output logic [5:0]  phys_page,
  output logic [31:0] flash_page_writes,
  output logic [31:0] host_page_writes,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  pmftl_pkg::cfg_t cfg;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.free_thr <= pmftl_pkg::FREE_THR_RESET;
      cfg.wear_gap <= pmftl_pkg::WEAR_GAP_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        pmftl_pkg::CFG_FREE_THR: cfg.free_thr <= cfg_data[5:0];
        pmftl_pkg::CFG_WEAR_GAP: cfg.wear_gap <= cfg_data;
        default: ;
      endcase
    end
  end

  pmftl_core u_core (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .action            (action),
    .logical_page      (logical_page),
    .cfg               (cfg),
    .busy              (busy),
    .done              (done),
    .status            (status),
    .was_mapped        (was_mapped),
    .phys_block        (phys_block),
    .phys_page         (phys_page),
    .flash_page_writes (flash_page_writes),
    .host_page_writes  (host_page_writes)
  );

endmodule

// ===== hw/rtl/pmftl_core.sv =====
module pmftl_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          action,
  input  logic [10:0]         logical_page,
  input  pmftl_pkg::cfg_t     cfg,
  output logic                busy,
  output logic                done,
  output logic                status,
  output logic                was_mapped,
  output logic [5:0]          phys_block,
  output logic [5:0]          phys_page,
  output logic [31:0]         flash_page_writes,
  output logic [31:0]         host_page_writes
);

  // memories
  pmftl_pkg::map_ent_t  map_mem  [pmftl_pkg::LOGICAL_PAGES];
  pmftl_pkg::page_ent_t page_mem [pmftl_pkg::TOTAL_PAGES];
  pmftl_pkg::blk_ent_t  blk_mem  [pmftl_pkg::BLOCK_COUNT];

  logic                 map_we, map_re;
  logic [10:0]          map_wa, map_ra;
  pmftl_pkg::map_ent_t  map_wd, map_rd;
  logic                 page_we, page_re;
  logic [11:0]          page_wa, page_ra;
  pmftl_pkg::page_ent_t page_wd, page_rd;
  logic                 blk_we, blk_re;
  logic [5:0]           blk_wa, blk_ra;
  pmftl_pkg::blk_ent_t  blk_wd, blk_rd;

  pmftl_pkg::state_t state;

  logic [1:0]  act_q;
  logic [10:0] lp;
  logic        was;
  logic        stat;
  logic [6:0]  rounds;
  logic [5:0]  active;
  logic [31:0] wc0, wc1;
  logic [10:0] clr;
  logic [6:0]  si;
  logic [6:0]  pc;

  // scan results
  logic [6:0]          nfree;
  logic                ff_found, inv_found, lv_found;
  logic [5:0]          ff_idx, inv_idx, lv_idx, mi_idx;
  pmftl_pkg::blk_ent_t ff_ent, inv_ent, lv_ent, mi_ent, act_ent;
  logic [6:0]          inv_best, lv_best;

  // move operands
  logic [5:0]          vb, db;
  pmftl_pkg::blk_ent_t v_ent, dst_ent;

  logic [5:0]          di;
  logic                vic_found;
  logic [5:0]          vic_idx;
  pmftl_pkg::blk_ent_t vic_ent;
  logic                fits;
  logic                wear_go;
  pmftl_pkg::blk_ent_t inv_upd, prg_upd;

  assign di = si[5:0] - 6'd1;

  // victim: most invalid pages, else fewest valid among programmed blocks
  always_comb begin
    vic_found = inv_found | lv_found;
    vic_idx   = inv_found ? inv_idx : lv_idx;
    vic_ent   = inv_found ? inv_ent : lv_ent;
    fits      = (7'd64 - act_ent.fill) >= vic_ent.vcnt;
    wear_go   = {1'b0, act_ent.ecnt} > ({1'b0, mi_ent.ecnt} + {25'd0, cfg.wear_gap});
  end

  // bookkeeping updates for invalidate and program
  always_comb begin
    inv_upd      = blk_rd;
    inv_upd.vcnt = (blk_rd.vcnt != 7'd0) ? blk_rd.vcnt - 7'd1 : blk_rd.vcnt;
    inv_upd.icnt = blk_rd.icnt + 7'd1;
    prg_upd      = blk_rd;
    prg_upd.fill = blk_rd.fill + 7'd1;
    prg_upd.vcnt = blk_rd.vcnt + 7'd1;
  end

  // memory port control
  always_comb begin
    map_we = 1'b0; map_wa = lp; map_wd = '0; map_re = 1'b0; map_ra = lp;
    page_we = 1'b0; page_wa = '0; page_wd = '0; page_re = 1'b0; page_ra = '0;
    blk_we = 1'b0; blk_wa = active; blk_wd = '0; blk_re = 1'b0; blk_ra = active;
    case (state)
      pmftl_pkg::S_CLEAR: begin
        map_we = 1'b1;
        map_wa = clr;
        blk_we = (clr[10:6] == 5'd0);
        blk_wa = clr[5:0];
      end
      pmftl_pkg::S_IDLE: begin
        map_re = start;
        map_ra = logical_page;
      end
      pmftl_pkg::S_SCAN: begin
        blk_re = !si[6];
        blk_ra = si[5:0];
      end
      pmftl_pkg::S_MV_RD: begin
        page_re = 1'b1;
        page_ra = {vb, pc[5:0]};
      end
      pmftl_pkg::S_MV_DAT: begin
        if (page_rd.vld) begin
          page_we = 1'b1;
          page_wa = {db, dst_ent.fill[5:0]};
          page_wd = '{vld: 1'b1, lpn: page_rd.lpn};
          map_we  = 1'b1;
          map_wa  = page_rd.lpn;
          map_wd  = '{vld: 1'b1, blk: db, pg: dst_ent.fill[5:0]};
        end
      end
      pmftl_pkg::S_MV_WDST: begin
        blk_we = 1'b1;
        blk_wa = db;
        blk_wd = dst_ent;
      end
      pmftl_pkg::S_MV_WVIC: begin
        blk_we = 1'b1;
        blk_wa = vb;
        blk_wd = '{fill: 7'd0, vcnt: 7'd0, icnt: 7'd0,
                   ecnt: pmftl_pkg::sat_inc32(v_ent.ecnt)};
      end
      pmftl_pkg::S_FIN, pmftl_pkg::S_OUT_RD: begin
        map_re = 1'b1;
      end
      pmftl_pkg::S_INV_RD: begin
        blk_re = map_rd.vld;
        blk_ra = map_rd.blk;
      end
      pmftl_pkg::S_INV_WR: begin
        blk_we  = 1'b1;
        blk_wa  = map_rd.blk;
        blk_wd  = inv_upd;
        page_we = 1'b1;
        page_wa = {map_rd.blk, map_rd.pg};
        page_wd = '{vld: 1'b0, lpn: lp};
      end
      pmftl_pkg::S_PRG_RD: begin
        blk_re = 1'b1;
      end
      pmftl_pkg::S_PRG_WR: begin
        if (blk_rd.fill < 7'd64) begin
          page_we = 1'b1;
          page_wa = {active, blk_rd.fill[5:0]};
          page_wd = '{vld: 1'b1, lpn: lp};
          map_we  = 1'b1;
          map_wd  = '{vld: 1'b1, blk: active, pg: blk_rd.fill[5:0]};
          blk_we  = 1'b1;
          blk_wd  = prg_upd;
        end
      end
      default: ;
    endcase
  end

  // memory arrays
  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    if (map_re) map_rd <= map_mem[map_ra];
  end

  always_ff @(posedge clk) begin
    if (page_we) page_mem[page_wa] <= page_wd;
    if (page_re) page_rd <= page_mem[page_ra];
  end

  always_ff @(posedge clk) begin
    if (blk_we) blk_mem[blk_wa] <= blk_wd;
    if (blk_re) blk_rd <= blk_mem[blk_ra];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= pmftl_pkg::S_CLEAR;
      clr    <= '0;
      active <= '0;
      wc0    <= '0;
      wc1    <= '0;
    end else begin
      case (state)
        pmftl_pkg::S_CLEAR: begin
          clr <= clr + 11'd1;
          if (clr == 11'h7FF) state <= pmftl_pkg::S_IDLE;
        end
        pmftl_pkg::S_IDLE: begin
          if (start) begin
            act_q  <= action;
            lp     <= logical_page;
            stat   <= 1'b0;
            rounds <= '0;
            si     <= '0;
            if (action == pmftl_pkg::ACT_WRITE) wc1 <= pmftl_pkg::sat_inc32(wc1);
            state <= pmftl_pkg::S_MAP0;
          end
        end
        pmftl_pkg::S_MAP0: begin
          was <= map_rd.vld;
          if (act_q == pmftl_pkg::ACT_WRITE || act_q == pmftl_pkg::ACT_WEAR)
            state <= pmftl_pkg::S_SCAN;
          else
            state <= pmftl_pkg::S_OUT;
        end
        pmftl_pkg::S_SCAN: begin
          if (si == 7'd0) begin
            nfree     <= '0;
            ff_found  <= 1'b0;
            inv_found <= 1'b0;
            inv_best  <= '0;
            lv_found  <= 1'b0;
          end else begin
            if (blk_rd.fill == 7'd0) begin
              nfree <= nfree + 7'd1;
              if (!ff_found) begin
                ff_found <= 1'b1;
                ff_idx   <= di;
                ff_ent   <= blk_rd;
              end
            end
            if (di == active) begin
              act_ent <= blk_rd;
            end else begin
              if (blk_rd.icnt > inv_best) begin
                inv_best  <= blk_rd.icnt;
                inv_found <= 1'b1;
                inv_idx   <= di;
                inv_ent   <= blk_rd;
              end
              if (blk_rd.fill != 7'd0 && (!lv_found || blk_rd.vcnt < lv_best)) begin
                lv_best  <= blk_rd.vcnt;
                lv_found <= 1'b1;
                lv_idx   <= di;
                lv_ent   <= blk_rd;
              end
            end
            if (di == 6'd0 || blk_rd.ecnt < mi_ent.ecnt) begin
              mi_idx <= di;
              mi_ent <= blk_rd;
            end
          end
          si <= si + 7'd1;
          if (si == 7'd64) state <= pmftl_pkg::S_DECIDE;
        end
        pmftl_pkg::S_DECIDE: begin
          pc <= '0;
          if (act_q == pmftl_pkg::ACT_WEAR) begin
            vb    <= mi_idx;
            v_ent <= mi_ent;
            db      <= ff_idx;
            dst_ent <= ff_ent;
            if (!wear_go) begin
              state <= pmftl_pkg::S_OUT_RD;
            end else if (!ff_found) begin
              stat  <= 1'b1;
              state <= pmftl_pkg::S_OUT_RD;
            end else begin
              state <= (mi_ent.fill != 7'd0) ? pmftl_pkg::S_MV_RD : pmftl_pkg::S_MV_WDST;
            end
          end else if (nfree >= {1'b0, cfg.free_thr}) begin
            state <= pmftl_pkg::S_FIN;
          end else if (rounds >= 7'(pmftl_pkg::MAX_GC_ROUNDS) || !vic_found ||
                       (!fits && !ff_found)) begin
            stat  <= 1'b1;
            state <= pmftl_pkg::S_OUT_RD;
          end else begin
            vb      <= vic_idx;
            v_ent   <= vic_ent;
            db      <= fits ? active : ff_idx;
            dst_ent <= fits ? act_ent : ff_ent;
            state <= (vic_ent.fill != 7'd0) ? pmftl_pkg::S_MV_RD : pmftl_pkg::S_MV_WDST;
          end
        end
        pmftl_pkg::S_MV_RD: begin
          state <= pmftl_pkg::S_MV_DAT;
        end
        pmftl_pkg::S_MV_DAT: begin
          if (page_rd.vld) begin
            dst_ent.fill <= dst_ent.fill + 7'd1;
            dst_ent.vcnt <= dst_ent.vcnt + 7'd1;
            wc0 <= pmftl_pkg::sat_inc32(wc0);
          end
          pc <= pc + 7'd1;
          state <= (pc + 7'd1 == v_ent.fill) ? pmftl_pkg::S_MV_WDST : pmftl_pkg::S_MV_RD;
        end
        pmftl_pkg::S_MV_WDST: begin
          state <= pmftl_pkg::S_MV_WVIC;
        end
        pmftl_pkg::S_MV_WVIC: begin
          if (act_q == pmftl_pkg::ACT_WEAR) begin
            state <= pmftl_pkg::S_OUT_RD;
          end else begin
            active <= db;
            rounds <= rounds + 7'd1;
            si     <= '0;
            state  <= pmftl_pkg::S_SCAN;
          end
        end
        pmftl_pkg::S_FIN: begin
          // open a fresh block when the active one is full
          if (act_ent.fill >= 7'd64) begin
            if (!ff_found) begin
              stat  <= 1'b1;
              state <= pmftl_pkg::S_OUT_RD;
            end else begin
              active <= ff_idx;
              state  <= pmftl_pkg::S_INV_RD;
            end
          end else begin
            state <= pmftl_pkg::S_INV_RD;
          end
        end
        pmftl_pkg::S_INV_RD: begin
          state <= map_rd.vld ? pmftl_pkg::S_INV_WR : pmftl_pkg::S_PRG_RD;
        end
        pmftl_pkg::S_INV_WR: begin
          state <= pmftl_pkg::S_PRG_RD;
        end
        pmftl_pkg::S_PRG_RD: begin
          state <= pmftl_pkg::S_PRG_WR;
        end
        pmftl_pkg::S_PRG_WR: begin
          if (blk_rd.fill < 7'd64) wc0 <= pmftl_pkg::sat_inc32(wc0);
          state <= pmftl_pkg::S_OUT_RD;
        end
        pmftl_pkg::S_OUT_RD: begin
          state <= pmftl_pkg::S_OUT;
        end
        pmftl_pkg::S_OUT: begin
          state <= pmftl_pkg::S_IDLE;
        end
        default: state <= pmftl_pkg::S_IDLE;
      endcase
    end
  end

  // result
  assign busy              = (state != pmftl_pkg::S_IDLE);
  assign done              = (state == pmftl_pkg::S_OUT);
  assign status            = stat;
  assign was_mapped        = was;
  assign phys_block        = map_rd.vld ? map_rd.blk : 6'd0;
  assign phys_page         = map_rd.vld ? map_rd.pg : 6'd0;
  assign flash_page_writes = wc0;
  assign host_page_writes  = wc1;

endmodule

// ===== hw/rtl/pmftl_checker.sv =====
module pmftl_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic       status,
  input logic       was_mapped,
  input logic [5:0] phys_block,
  input logic [5:0] phys_page
);

  // clearing pass follows reset
  a_rst_busy: assert property (@(posedge clk) rst |=> busy)
    else $error("not busy after reset");

  // an accepted item keeps the block busy
  a_acc_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy low after transfer");

  // a result ends the item and is never repeated
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result repeated");

  // an unmapped page cannot gain a mapping through a failed write
  a_fail_unmapped: assert property (@(posedge clk) disable iff (rst)
    (done && status && !was_mapped) |-> (phys_block == 6'd0 && phys_page == 6'd0))
    else $error("failed item mapped a page");

endmodule

bind page_mapped_ftl_greedy_gc_top pmftl_checker u_pmftl_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .status     (status),
  .was_mapped (was_mapped),
  .phys_block (phys_block),
  .phys_page  (phys_page)
);

// ===== dv/page_mapped_ftl_greedy_gc_checker.sv =====
module page_mapped_ftl_greedy_gc_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  action,
  input  logic [10:0] logical_page,
  input  logic        done,
  input  logic        status,
  input  logic        was_mapped,
  input  logic [5:0]  phys_block,
  input  logic [5:0]  phys_page,
  input  logic [31:0] flash_page_writes,
  input  logic [31:0] host_page_writes,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  output int          errors,
  output int          pending,
  output int          checked,
  output int          refused
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] PG_FREE    = 2'd0;
  localparam logic [1:0] PG_LIVE    = 2'd1;
  localparam logic [1:0] PG_STALE   = 2'd2;

  typedef struct {
    logic        status;
    logic        mapped;
    logic [5:0]  blk;
    logic [5:0]  pg;
    logic [31:0] flash_wr;
    logic [31:0] host_wr;
  } ftl_result_t;

  // shadow flash state
  bit          lmap_vld [pmftl_pkg::LOGICAL_PAGES];
  int          lmap_blk [pmftl_pkg::LOGICAL_PAGES];
  int          lmap_pg  [pmftl_pkg::LOGICAL_PAGES];
  logic [1:0]  page_st  [pmftl_pkg::TOTAL_PAGES];
  int          page_lpn [pmftl_pkg::TOTAL_PAGES];
  int          fill [pmftl_pkg::BLOCK_COUNT];
  int          vcnt [pmftl_pkg::BLOCK_COUNT];
  int          icnt [pmftl_pkg::BLOCK_COUNT];
  logic [31:0] ecnt [pmftl_pkg::BLOCK_COUNT];
  int          open_blk;
  logic [31:0] flash_wr_cnt, host_wr_cnt;
  int          free_thr, wear_gap;

  ftl_result_t expected_q [$];
  ftl_result_t want;

  function automatic logic [31:0] inc_sat(input logic [31:0] x);
    return (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
  endfunction

  function automatic void clear_state();
    for (int i = 0; i < pmftl_pkg::LOGICAL_PAGES; i++) begin
      lmap_vld[i] = 0; lmap_blk[i] = 0; lmap_pg[i] = 0;
    end
    for (int i = 0; i < pmftl_pkg::TOTAL_PAGES; i++) begin
      page_st[i] = PG_FREE; page_lpn[i] = 0;
    end
    for (int i = 0; i < pmftl_pkg::BLOCK_COUNT; i++) begin
      fill[i] = 0; vcnt[i] = 0; icnt[i] = 0; ecnt[i] = 0;
    end
    open_blk = 0;
    flash_wr_cnt = 0;
    host_wr_cnt = 0;
    free_thr = pmftl_pkg::FREE_THR_RESET;
    wear_gap = pmftl_pkg::WEAR_GAP_RESET;
  endfunction

  function automatic void program_slot(input int b, input int lpn);
    int p;
    if (fill[b] >= pmftl_pkg::PAGES_IN_BLOCK) return;
    p = fill[b];
    page_st[b * pmftl_pkg::PAGES_IN_BLOCK + p] = PG_LIVE;
    page_lpn[b * pmftl_pkg::PAGES_IN_BLOCK + p] = lpn;
    fill[b]++;
    vcnt[b]++;
    lmap_vld[lpn] = 1; lmap_blk[lpn] = b; lmap_pg[lpn] = p;
    flash_wr_cnt = inc_sat(flash_wr_cnt);
  endfunction

  function automatic void erase_blk(input int b);
    for (int i = 0; i < pmftl_pkg::PAGES_IN_BLOCK; i++) begin
      page_st[b * pmftl_pkg::PAGES_IN_BLOCK + i] = PG_FREE;
      page_lpn[b * pmftl_pkg::PAGES_IN_BLOCK + i] = 0;
    end
    fill[b] = 0; vcnt[b] = 0; icnt[b] = 0;
    ecnt[b] = inc_sat(ecnt[b]);
  endfunction

  function automatic void relocate_live(input int src, input int dst);
    for (int i = 0; i < pmftl_pkg::PAGES_IN_BLOCK; i++)
      if (page_st[src * pmftl_pkg::PAGES_IN_BLOCK + i] == PG_LIVE)
        program_slot(dst, page_lpn[src * pmftl_pkg::PAGES_IN_BLOCK + i]);
  endfunction

  function automatic int free_blocks();
    int n;
    n = 0;
    for (int i = 0; i < pmftl_pkg::BLOCK_COUNT; i++) if (fill[i] == 0) n++;
    return n;
  endfunction

  function automatic int lowest_free();
    for (int i = 0; i < pmftl_pkg::BLOCK_COUNT; i++) if (fill[i] == 0) return i;
    return -1;
  endfunction

  // greedy pick: most stale pages, else fewest live pages among used blocks
  function automatic int choose_victim();
    int best, most, least;
    best = -1; most = 0; least = 1 << 30;
    for (int i = 0; i < pmftl_pkg::BLOCK_COUNT; i++)
      if (i != open_blk && icnt[i] > most) begin
        most = icnt[i]; best = i;
      end
    if (best >= 0) return best;
    for (int i = 0; i < pmftl_pkg::BLOCK_COUNT; i++)
      if (i != open_blk && fill[i] != 0 && vcnt[i] < least) begin
        least = vcnt[i]; best = i;
      end
    return best;
  endfunction

  function automatic bit collect_once();
    int v, nb;
    v = choose_victim();
    if (v < 0) return 0;
    if (pmftl_pkg::PAGES_IN_BLOCK - fill[open_blk] >= vcnt[v]) begin
      relocate_live(v, open_blk);
      erase_blk(v);
      return 1;
    end
    nb = lowest_free();
    if (nb < 0) return 0;
    relocate_live(v, nb);
    erase_blk(v);
    open_blk = nb;
    return 1;
  endfunction

  function automatic logic host_write(input int lp);
    int rounds, nb, old;
    rounds = 0;
    host_wr_cnt = inc_sat(host_wr_cnt);
    while (free_blocks() < free_thr) begin
      if (rounds >= pmftl_pkg::MAX_GC_ROUNDS || !collect_once()) return 1'b1;
      rounds++;
    end
    if (fill[open_blk] >= pmftl_pkg::PAGES_IN_BLOCK) begin
      nb = lowest_free();
      if (nb < 0) return 1'b1;
      open_blk = nb;
    end
    if (lmap_vld[lp]) begin
      old = lmap_blk[lp];
      page_st[old * pmftl_pkg::PAGES_IN_BLOCK + lmap_pg[lp]] = PG_STALE;
      if (vcnt[old] > 0) vcnt[old]--;
      icnt[old]++;
    end
    program_slot(open_blk, lp);
    return 1'b0;
  endfunction

  function automatic logic level_wear();
    int mi, fb;
    mi = 0;
    for (int i = 1; i < pmftl_pkg::BLOCK_COUNT; i++) if (ecnt[i] < ecnt[mi]) mi = i;
    if (64'(ecnt[open_blk]) > 64'(ecnt[mi]) + 64'(wear_gap)) begin
      fb = lowest_free();
      if (fb < 0) return 1'b1;
      relocate_live(mi, fb);
      erase_blk(mi);
    end
    return 1'b0;
  endfunction

  function automatic ftl_result_t predict_item(input logic [1:0] a, input logic [10:0] l);
    ftl_result_t r;
    int lp;
    lp = int'(l) % pmftl_pkg::LOGICAL_PAGES;
    r.mapped = lmap_vld[lp];
    r.status = 1'b0;
    if (a == pmftl_pkg::ACT_WRITE) r.status = host_write(lp);
    else if (a == pmftl_pkg::ACT_WEAR) r.status = level_wear();
    r.blk = lmap_vld[lp] ? 6'(lmap_blk[lp]) : 6'd0;
    r.pg  = lmap_vld[lp] ? 6'(lmap_pg[lp]) : 6'd0;
    r.flash_wr = flash_wr_cnt;
    r.host_wr = host_wr_cnt;
    return r;
  endfunction

  task automatic report(input string what, input logic [31:0] exp_v, input logic [31:0] got_v);
    $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
    errors++;
  endtask

  initial begin
    errors = 0; pending = 0; checked = 0; refused = 0;
    clear_state();
  end

  // watch config, result and command transfers, in that order
  always @(posedge clk) begin
    if (rst) begin
      clear_state();
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == pmftl_pkg::CFG_FREE_THR) free_thr = int'(cfg_data[5:0]);
        else wear_gap = int'(cfg_data);
      end
      if (done) begin
        if (expected_q.size() == 0) begin
          report("outstanding results", 32'd1, 32'd0);
        end else begin
          want = expected_q.pop_front();
          checked++;
          if (status) refused++;
          if (status !== want.status) report("status", want.status, status);
          if (was_mapped !== want.mapped) report("was_mapped", want.mapped, was_mapped);
          if (phys_block !== want.blk) report("phys_block", want.blk, phys_block);
          if (phys_page !== want.pg) report("phys_page", want.pg, phys_page);
          if (flash_page_writes !== want.flash_wr)
            report("flash_page_writes", want.flash_wr, flash_page_writes);
          if (host_page_writes !== want.host_wr)
            report("host_page_writes", want.host_wr, host_page_writes);
        end
      end
      if (start && !busy) expected_q.push_back(predict_item(action, logical_page));
    end
    pending <= expected_q.size();
  end

endmodule

// ===== dv/page_mapped_ftl_greedy_gc_top_test.sv =====
module page_mapped_ftl_greedy_gc_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  action = pmftl_pkg::ACT_READ;
  logic [10:0] logical_page = '0;
  logic        busy, done, status, was_mapped;
  logic [5:0]  phys_block, phys_page;
  logic [31:0] flash_page_writes, host_page_writes;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = pmftl_pkg::CFG_FREE_THR;
  logic [7:0]  cfg_data = '0;
  int          errors, pending, checked, refused;
  int          sent;

  always #5 clk = ~clk;

  page_mapped_ftl_greedy_gc_top DUT (
    .clk(clk), .rst(rst), .start(start), .action(action),
    .logical_page(logical_page), .busy(busy), .done(done), .status(status),
    .was_mapped(was_mapped), .phys_block(phys_block), .phys_page(phys_page),
    .flash_page_writes(flash_page_writes), .host_page_writes(host_page_writes),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  page_mapped_ftl_greedy_gc_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .logical_page(logical_page), .done(done), .status(status),
    .was_mapped(was_mapped), .phys_block(phys_block), .phys_page(phys_page),
    .flash_page_writes(flash_page_writes), .host_page_writes(host_page_writes),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .errors(errors), .pending(pending), .checked(checked),
    .refused(refused)
  );

  // one command transfer; start is left high for a following item
  task automatic send_cmd(input logic [1:0] a, input logic [10:0] lp);
    start <= 1'b1;
    action <= a;
    logical_page <= lp;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic hold_off(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0 || busy);
  endtask

  // both registers in one valid stretch
  task automatic set_thresholds(input logic [7:0] free_val, input logic [7:0] gap_val);
    cfg_valid <= 1'b1;
    cfg_index <= pmftl_pkg::CFG_FREE_THR;
    cfg_data <= free_val;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= pmftl_pkg::CFG_WEAR_GAP;
    cfg_data <= gap_val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [1:0] pick_action();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return pmftl_pkg::ACT_WRITE;
    if (r < 85) return pmftl_pkg::ACT_READ;
    if (r < 95) return pmftl_pkg::ACT_WEAR;
    return pmftl_pkg::ACT_SPARE;
  endfunction

  // random items in bursts, pages drawn mostly from a hot set
  task automatic random_phase(input int n, input int hot);
    int burst, left;
    logic [10:0] lp;
    left = n;
    while (left > 0) begin
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      for (int i = 0; i < burst && left > 0; i++) begin
        lp = ($urandom_range(0, 99) < 85) ? 11'($urandom_range(0, hot - 1))
                                           : 11'($urandom_range(0, 2047));
        send_cmd(pick_action(), lp);
        left--;
      end
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 40));
    end
  endtask

  logic [7:0] free_set [6] = '{8'd3, 8'd63, 8'hC1, 8'd48, 8'd63, 8'd20};
  logic [7:0] gap_set  [6] = '{8'd5, 8'd0, 8'd255, 8'd1, 8'd0, 8'd3};
  int         hot_set  [6] = '{2048, 200, 96, 400, 64, 1024};

  initial begin
    sent = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    set_thresholds(free_set[0], gap_set[0]);

    // directed: field extremes, rewrites, unused action code, wear level
    send_cmd(pmftl_pkg::ACT_READ, 11'd0);
    send_cmd(pmftl_pkg::ACT_READ, 11'd2047);
    send_cmd(pmftl_pkg::ACT_WRITE, 11'd0);
    send_cmd(pmftl_pkg::ACT_WRITE, 11'd2047);
    send_cmd(pmftl_pkg::ACT_READ, 11'd0);
    send_cmd(pmftl_pkg::ACT_READ, 11'd2047);
    send_cmd(pmftl_pkg::ACT_WRITE, 11'd0);
    send_cmd(pmftl_pkg::ACT_SPARE, 11'd1365);
    send_cmd(pmftl_pkg::ACT_SPARE, 11'd2047);
    send_cmd(pmftl_pkg::ACT_WEAR, 11'd682);
    send_cmd(pmftl_pkg::ACT_WRITE, 11'd1365);
    send_cmd(pmftl_pkg::ACT_WRITE, 11'd682);
    send_cmd(pmftl_pkg::ACT_READ, 11'd1365);
    send_cmd(pmftl_pkg::ACT_WRITE, 11'd1365);
    send_cmd(pmftl_pkg::ACT_READ, 11'd682);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph != 0) set_thresholds(free_set[ph], gap_set[ph]);
      random_phase(125, hot_set[ph]);
      // sender waits for every outstanding result mid-phase
      drain();
      random_phase(125, hot_set[ph]);
      drain();
    end

    repeat (20) @(posedge clk);
    $display("Sent %0d commands over 6 threshold settings plus a directed set.", sent);
    $display("Checked %0d results, %0d of them refused writes or relocations.",
             checked, refused);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #1_000_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
